// File: src/ppeu_pkg.sv
// package: shared types, codes and helpers of the packed pattern event unpacker
`timescale 1ns / 1ps
package ppeu_pkg;

	localparam logic [7:0] GRP_NOTE   = 8'h80;
	localparam logic [7:0] GRP_VOLUME = 8'h40;
	localparam logic [7:0] GRP_EFFECT = 8'h20;
	localparam logic [7:0] CHAN_MASK  = 8'h1f;

	localparam int CHAN_W = 5;

	localparam logic [2:0] PEND_NOTE   = 3'b100;
	localparam logic [2:0] PEND_VOL    = 3'b010;
	localparam logic [2:0] PEND_EFFECT = 3'b001;

	localparam logic [7:0] ROWS_RESET  = 8'd64;
	localparam logic [7:0] CHANS_RESET = 8'd32;

	typedef enum logic [0:0] {
		REG_ROWS  = 1'b0,
		REG_CHANS = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_FLAGS  = 3'd0,
		PH_NOTE   = 3'd1,
		PH_INSTR  = 3'd2,
		PH_VOL    = 3'd3,
		PH_EFFECT = 3'd4,
		PH_PARAM  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]        row;
		logic [CHAN_W-1:0] channel;
		logic [7:0]        note;
		logic [7:0]        instrument;
		logic [7:0]        volume;
		logic [7:0]        effect;
		logic [7:0]        effect_param;
	} evt_t;

	typedef struct packed {
		logic [7:0] rows;
		logic [7:0] chans;
	} cfg_t;

	// first group still due, flags phase when none
	function automatic phase_t next_phase(input logic [2:0] pend);
		phase_t ph;
		if ((pend & PEND_NOTE) != 3'b000) begin
			ph = PH_NOTE;
		end else if ((pend & PEND_VOL) != 3'b000) begin
			ph = PH_VOL;
		end else if ((pend & PEND_EFFECT) != 3'b000) begin
			ph = PH_EFFECT;
		end else begin
			ph = PH_FLAGS;
		end
		return ph;
	endfunction

endpackage

// File: src/ppeu_byte_if.sv
// interface: byte stream channel with valid/ready handshake
`timescale 1ns / 1ps
interface ppeu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: src/ppeu_event_if.sv
// interface: decoded event channel with valid/ready handshake
`timescale 1ns / 1ps
interface ppeu_event_if;
	logic       valid;
	logic       ready;
	logic [7:0] row;
	logic [4:0] channel;
	logic [7:0] note;
	logic [7:0] instrument;
	logic [7:0] volume;
	logic [7:0] effect;
	logic [7:0] effect_param;

	modport source (
		output valid, output row, output channel, output note, output instrument,
		output volume, output effect, output effect_param, input ready
	);
	modport sink (
		input valid, input row, input channel, input note, input instrument,
		input volume, input effect, input effect_param, output ready
	);
endinterface

// File: src/ppeu_decoder.sv
// module: per-byte phase state machine and event field assembly
`timescale 1ns / 1ps
module ppeu_decoder
	import ppeu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  cfg_t       cfg,
	output logic       evt_valid,
	output evt_t       evt
);

	phase_t            phase_q, phase_nx;
	logic [2:0]        pend_q, pend_nx;
	logic [CHAN_W-1:0] chan_q, chan_nx;
	logic [7:0]        row_q, row_nx;
	logic [7:0]        held_q, held_nx;
	logic [7:0]        note_q, note_nx;
	logic [7:0]        instr_q, instr_nx;
	logic [7:0]        vol_q, vol_nx;
	logic [7:0]        eff_q, eff_nx;
	logic [7:0]        param_q, param_nx;
	logic              done;
	logic [2:0]        pend_flags;

	assign pend_flags = {(data_byte & GRP_NOTE) != 8'h00,
		(data_byte & GRP_VOLUME) != 8'h00,
		(data_byte & GRP_EFFECT) != 8'h00};

	// next state
	always_comb begin
		phase_nx = phase_q;
		pend_nx  = pend_q;
		chan_nx  = chan_q;
		row_nx   = row_q;
		held_nx  = held_q;
		note_nx  = note_q;
		instr_nx = instr_q;
		vol_nx   = vol_q;
		eff_nx   = eff_q;
		param_nx = param_q;
		done     = 1'b0;
		unique case (phase_q)
			PH_NOTE: begin
				held_nx  = data_byte;
				phase_nx = PH_INSTR;
				done     = last_byte;
			end
			PH_INSTR: begin
				note_nx  = held_q;
				instr_nx = data_byte;
				pend_nx  = pend_q & ~PEND_NOTE;
				phase_nx = next_phase(pend_nx);
				done     = (phase_nx == PH_FLAGS) || last_byte;
			end
			PH_VOL: begin
				vol_nx   = data_byte;
				pend_nx  = pend_q & ~PEND_VOL;
				phase_nx = next_phase(pend_nx);
				done     = (phase_nx == PH_FLAGS) || last_byte;
			end
			PH_EFFECT: begin
				held_nx  = data_byte;
				phase_nx = PH_PARAM;
				done     = last_byte;
			end
			PH_PARAM: begin
				eff_nx   = held_q;
				param_nx = data_byte;
				pend_nx  = pend_q & ~PEND_EFFECT;
				done     = 1'b1;
			end
			PH_FLAGS: begin
				if (row_q >= cfg.rows) begin
					done = 1'b0;
				end else if (data_byte == 8'h00) begin
					row_nx = row_q + 8'd1;
				end else begin
					chan_nx  = data_byte[CHAN_W-1:0];
					note_nx  = 8'h00;
					instr_nx = 8'h00;
					vol_nx   = 8'h00;
					eff_nx   = 8'h00;
					param_nx = 8'h00;
					pend_nx  = pend_flags;
					phase_nx = next_phase(pend_flags);
					done     = (phase_nx == PH_FLAGS) || last_byte;
				end
			end
			default: begin
				phase_nx = PH_FLAGS;
			end
		endcase
		if (done) begin
			phase_nx = PH_FLAGS;
			pend_nx  = 3'b000;
		end
	end

	// outputs
	always_comb begin
		evt_valid        = accept && done && ({3'b000, chan_nx} < cfg.chans);
		evt.row          = row_q;
		evt.channel      = chan_nx;
		evt.note         = note_nx;
		evt.instrument   = instr_nx;
		evt.volume       = vol_nx;
		evt.effect       = eff_nx;
		evt.effect_param = param_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAGS;
			pend_q  <= 3'b000;
			chan_q  <= '0;
			row_q   <= 8'h00;
			held_q  <= 8'h00;
			note_q  <= 8'h00;
			instr_q <= 8'h00;
			vol_q   <= 8'h00;
			eff_q   <= 8'h00;
			param_q <= 8'h00;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= PH_FLAGS;
				pend_q  <= 3'b000;
				chan_q  <= '0;
				row_q   <= 8'h00;
				held_q  <= 8'h00;
				note_q  <= 8'h00;
				instr_q <= 8'h00;
				vol_q   <= 8'h00;
				eff_q   <= 8'h00;
				param_q <= 8'h00;
			end else begin
				phase_q <= phase_nx;
				pend_q  <= pend_nx;
				chan_q  <= chan_nx;
				row_q   <= row_nx;
				held_q  <= held_nx;
				note_q  <= note_nx;
				instr_q <= instr_nx;
				vol_q   <= vol_nx;
				eff_q   <= eff_nx;
				param_q <= param_nx;
			end
		end
	end

endmodule

// File: src/ppeu_out_reg.sv
// module: result register driving the event channel
`timescale 1ns / 1ps
module ppeu_out_reg
	import ppeu_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  evt_valid,
	input  evt_t  evt,
	output logic  can_take,
	ppeu_event_if.source events
);

	logic valid_q;
	evt_t evt_q;

	assign can_take = !valid_q || events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && evt_valid) begin
			evt_q <= evt;
		end
	end

	assign events.valid        = valid_q;
	assign events.row          = evt_q.row;
	assign events.channel      = evt_q.channel;
	assign events.note         = evt_q.note;
	assign events.instrument   = evt_q.instrument;
	assign events.volume       = evt_q.volume;
	assign events.effect       = evt_q.effect;
	assign events.effect_param = evt_q.effect_param;

endmodule

// File: src/packed_pattern_event_unpacker_core.sv
// top level: packed pattern event unpacker with configuration registers
// Takes one byte of packed pattern data per clock while bytes.ready is high and gives
// at most one decoded event per byte. The event of a byte appears on the event
// channel in the cycle after the byte transaction, from a single result register;
// the byte channel stays ready while that register is empty or being taken, so
// with an open event channel a byte goes in every cycle. The phase state register
// is updated once per accepted byte. Configuration writes are meant for idle
// periods between patterns; the byte flagged last_byte returns all decode state
// to its reset values.
`timescale 1ns / 1ps
module packed_pattern_event_unpacker_core
	import ppeu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	ppeu_byte_if.sink  bytes,
	ppeu_event_if.source events
);

	cfg_t cfg_q;
	logic accept;
	logic can_take;
	logic evt_valid;
	evt_t evt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows  <= ROWS_RESET;
			cfg_q.chans <= CHANS_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROWS:  cfg_q.rows  <= cfg_wdata;
				REG_CHANS: cfg_q.chans <= cfg_wdata;
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	assign bytes.ready = can_take;
	assign accept      = bytes.valid && can_take;

	ppeu_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (bytes.data_byte),
		.last_byte (bytes.last_byte),
		.cfg       (cfg_q),
		.evt_valid (evt_valid),
		.evt       (evt)
	);

	ppeu_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt       (evt),
		.can_take  (can_take),
		.events    (events)
	);

endmodule
